>>> sv/sfr_pkg.sv
// Shared types, codes and descriptor constants for the SFrame RTP reassembly block.
`timescale 1ns / 1ps

package sfr_pkg;

  // Descriptor bit masks, low 8 bits of the descriptor byte
  localparam logic [7:0] START_MASK  = 8'h80;
  localparam logic [7:0] END_MASK    = 8'h40;
  localparam logic [7:0] ORIGIN_MASK = 8'h20;

  localparam logic [16:0] MAX_FRAME_BYTES = 17'd65536;

  // Action codes
  localparam logic [1:0] ACT_DROP   = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_EMIT   = 2'd2;
  localparam logic [1:0] ACT_PASS   = 2'd3;

  // Drop reasons
  localparam logic [2:0] RSN_NONE     = 3'd0;
  localparam logic [2:0] RSN_T_BIT    = 3'd1;
  localparam logic [2:0] RSN_RESERVED = 3'd2;
  localparam logic [2:0] RSN_NO_FRAME = 3'd3;
  localparam logic [2:0] RSN_TIMESTAMP = 3'd4;
  localparam logic [2:0] RSN_SEQUENCE = 3'd5;
  localparam logic [2:0] RSN_OVERSIZE = 3'd6;

  // Packet class decided by the front end
  localparam logic [1:0] KIND_PASS   = 2'd0;
  localparam logic [1:0] KIND_ORIGIN = 2'd1;
  localparam logic [1:0] KIND_RSVD   = 2'd2;
  localparam logic [1:0] KIND_MEDIA  = 2'd3;

  typedef struct packed {
    logic        is_control;
    logic [7:0]  descriptor;
    logic [31:0] rtp_timestamp;
    logic [15:0] seq_number;
    logic [6:0]  payload_type;
    logic [15:0] payload_length;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        flush_partial;
    logic [2:0]  drop_reason;
    logic [31:0] frame_timestamp;
    logic [6:0]  frame_payload_type;
    logic [16:0] frame_length;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_start;
    logic        is_end;
    logic [31:0] rtp_timestamp;
    logic [15:0] seq_number;
    logic [6:0]  payload_type;
    logic [15:0] payload_length;
  } cmd_t;

endpackage

>>> sv/sfr_ifs.sv
// Channel interfaces: packet input, result output and configuration write.
`timescale 1ns / 1ps

interface sfr_in_if;
  import sfr_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfr_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/sfr_front.sv
// Front end: config register, packet accept and descriptor classification.
`timescale 1ns / 1ps

module sfr_front (
  input  logic          clk,
  input  logic          rst_n,
  sfr_in_if.sink        in_ch,
  sfr_cfg_if.sink       cfg_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output sfr_pkg::cmd_t push_data
);
  import sfr_pkg::*;

  logic       sframe_on_r;
  logic [7:0] desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sframe_on_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      sframe_on_r <= cfg_ch.data;
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign push_valid   = in_ch.valid;
  assign desc         = in_ch.data.descriptor;

  always_comb begin
    push_data.is_start       = (desc & START_MASK) != 8'h00;
    push_data.is_end         = (desc & END_MASK) != 8'h00;
    push_data.rtp_timestamp  = in_ch.data.rtp_timestamp;
    push_data.seq_number     = in_ch.data.seq_number;
    push_data.payload_type   = in_ch.data.payload_type;
    push_data.payload_length = in_ch.data.payload_length;
    priority if (!sframe_on_r || in_ch.data.is_control) begin
      push_data.kind = KIND_PASS;
    end else if ((desc & ORIGIN_MASK) != 8'h00) begin
      push_data.kind = KIND_ORIGIN;
    end else if ((desc & ~(START_MASK | END_MASK)) != 8'h00) begin
      push_data.kind = KIND_RSVD;
    end else begin
      push_data.kind = KIND_MEDIA;
    end
  end

endmodule

>>> sv/sfr_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module sfr_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  sfr_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sfr_pkg::cmd_t pop_data
);
  import sfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != FULL;
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("queue count beyond depth");
`endif

endmodule

>>> sv/sfr_back.sv
// Back end: frame state, drop/append/emit/pass decision and output register.
`timescale 1ns / 1ps

module sfr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  sfr_pkg::cmd_t q_data,
  sfr_out_if.source     out_ch
);
  import sfr_pkg::*;

  logic [16:0] part_len_r, part_len_nxt;
  logic [31:0] held_ts_r, held_ts_nxt;
  logic [6:0]  held_pt_r, held_pt_nxt;
  logic [15:0] exp_seq_r, exp_seq_nxt;
  logic        out_valid_r;
  out_word_t   out_data_r;
  out_word_t   res;
  logic        pop;
  logic        has_part;
  logic [16:0] base_len;
  logic [17:0] sum_len;

  assign pop      = q_valid && (!out_valid_r || out_ch.ready);
  assign q_ready  = !out_valid_r || out_ch.ready;
  assign has_part = part_len_r != '0;
  assign base_len = q_data.is_start ? 17'd0 : part_len_r;
  assign sum_len  = {1'b0, base_len} + {2'b00, q_data.payload_length};

  always_comb begin
    part_len_nxt = part_len_r;
    held_ts_nxt  = held_ts_r;
    held_pt_nxt  = held_pt_r;
    exp_seq_nxt  = exp_seq_r;
    res          = '0;
    res.action   = ACT_PASS;
    unique case (q_data.kind)
      KIND_PASS: begin
      end
      KIND_ORIGIN: begin
        res.action        = ACT_DROP;
        res.flush_partial = has_part;
        res.drop_reason   = RSN_T_BIT;
        part_len_nxt      = '0;
      end
      KIND_RSVD: begin
        res.action        = ACT_DROP;
        res.flush_partial = has_part;
        res.drop_reason   = RSN_RESERVED;
        part_len_nxt      = '0;
      end
      KIND_MEDIA: begin
        priority if (!q_data.is_start && !has_part) begin
          res.action      = ACT_DROP;
          res.drop_reason = RSN_NO_FRAME;
        end else if (!q_data.is_start && q_data.rtp_timestamp != held_ts_r) begin
          res.action        = ACT_DROP;
          res.flush_partial = 1'b1;
          res.drop_reason   = RSN_TIMESTAMP;
          part_len_nxt      = '0;
        end else if (!q_data.is_start && q_data.seq_number != exp_seq_r) begin
          res.action        = ACT_DROP;
          res.flush_partial = 1'b1;
          res.drop_reason   = RSN_SEQUENCE;
          part_len_nxt      = '0;
        end else begin
          exp_seq_nxt = q_data.seq_number + 16'd1;
          if (q_data.is_start) begin
            held_ts_nxt = q_data.rtp_timestamp;
            held_pt_nxt = q_data.payload_type;
          end
          // a start throws away the old frame; a continuation extends it
          res.flush_partial = q_data.is_start && has_part;
          priority if (sum_len > {1'b0, MAX_FRAME_BYTES}) begin
            res.action        = ACT_DROP;
            res.flush_partial = has_part;
            res.drop_reason   = RSN_OVERSIZE;
            part_len_nxt      = '0;
          end else if (!q_data.is_end) begin
            res.action   = ACT_APPEND;
            part_len_nxt = sum_len[16:0];
          end else begin
            res.action             = ACT_EMIT;
            res.frame_timestamp    = held_ts_nxt;
            res.frame_payload_type = held_pt_nxt;
            res.frame_length       = sum_len[16:0];
            part_len_nxt           = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_len_r  <= '0;
      held_ts_r   <= '0;
      held_pt_r   <= '0;
      exp_seq_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        part_len_r  <= part_len_nxt;
        held_ts_r   <= held_ts_nxt;
        held_pt_r   <= held_pt_nxt;
        exp_seq_r   <= exp_seq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    part_len_r <= MAX_FRAME_BYTES)
    else $error("partial length beyond frame limit");

  a_drop_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_data_r.action == ACT_DROP) == (out_data_r.drop_reason != RSN_NONE)))
    else $error("drop reason does not match action");

  a_frame_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && res.action != ACT_APPEND && res.action != ACT_PASS) |=> part_len_r == '0)
    else $error("frame still open after drop or emit");
`endif

endmodule

>>> sv/sframe_rtp_frame_reassembly_top.sv
// Top level of the SFrame RTP frame reassembly control block.
// A word accepted on in_ch passes through the command queue and the output register.
// Throughput: one word per cycle while out_ch does not stall.
// The command queue (QUEUE_DEPTH entries) lets the input and output sides stall apart.
// Reset (rst_n low, synchronous) clears sframe_on, the frame state and all valids.
`timescale 1ns / 1ps

module sframe_rtp_frame_reassembly_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  sfr_in_if.sink     in_ch,
  sfr_cfg_if.sink    cfg_ch,
  sfr_out_if.source  out_ch
);
  import sfr_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_data;
  logic q_valid, q_ready;
  cmd_t q_data;

  sfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  sfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .out_ch  (out_ch)
  );

endmodule
